@@ sv/itp_pkg.sv @@
package itp_pkg;

  localparam logic [7:0] CH_CARET  = 8'h5e;  // '^'
  localparam logic [7:0] CH_STAR   = 8'h2a;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2f;  // '/'
  localparam logic [7:0] CH_PLUS   = 8'h2b;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2d;  // '-'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CLOSE    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_OPEN     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPERATOR,
    CLS_OTHER
  } sym_class_e;

  typedef enum logic [1:0] {
    SRC_SYMBOL,
    SRC_TOP,
    SRC_MARK
  } emit_src_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic       capture;
    logic       push;
    logic       pop;
    logic       emit;
    emit_src_e  src;
    status_e    mark_status;
    logic       set_open;
    logic       finish;
  } itp_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    sym_class_e cls;
    logic       empty;
    logic       full;
    logic       top_lparen;
    logic       pop_cond;
    logic       emit_ok;
    logic       out_free;
    logic       last;
    logic       open_seen;
  } itp_sts_t;

  function automatic logic [1:0] precedence(input logic [7:0] ch);
    logic [1:0] p;
    case (ch)
      CH_CARET:           p = 2'd3;
      CH_STAR, CH_SLASH:  p = 2'd2;
      CH_PLUS, CH_MINUS:  p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic sym_class_e classify(input logic [7:0] ch);
    sym_class_e c;
    if ((ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) ||
        (ch >= 8'h30 && ch <= 8'h39)) begin
      c = CLS_OPERAND;
    end else if (ch == CH_LPAREN) begin
      c = CLS_LPAREN;
    end else if (ch == CH_RPAREN) begin
      c = CLS_RPAREN;
    end else if (precedence(ch) != 2'd0) begin
      c = CLS_OPERATOR;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

@@ sv/itp_ctrl.sv @@
module itp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itp_pkg::itp_sts_t sts_i,
  output itp_pkg::itp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLOSE,
    S_OPPOP,
    S_FLUSH,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  state_e after_item;

  always_comb begin
    cmd_o             = '0;
    cmd_o.src         = itp_pkg::SRC_MARK;
    cmd_o.mark_status = itp_pkg::ST_OK;
    state_d           = state_q;
    in_ready_o        = 1'b0;
    after_item        = sts_i.last ? S_FLUSH : S_IDLE;

    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.cls)
          itp_pkg::CLS_OPERAND: begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = itp_pkg::SRC_SYMBOL;
            if (sts_i.emit_ok) state_d = after_item;
          end
          itp_pkg::CLS_LPAREN: begin
            if (sts_i.full) begin
              cmd_o.emit        = 1'b1;
              cmd_o.mark_status = itp_pkg::ST_OVERFLOW;
              if (sts_i.emit_ok) state_d = after_item;
            end else begin
              cmd_o.push = 1'b1;
              state_d    = after_item;
            end
          end
          itp_pkg::CLS_RPAREN:   state_d = S_CLOSE;
          itp_pkg::CLS_OPERATOR: state_d = S_OPPOP;
          default:               state_d = after_item;
        endcase
      end
      S_CLOSE: begin
        if (sts_i.empty) begin
          cmd_o.emit        = 1'b1;
          cmd_o.mark_status = itp_pkg::ST_CLOSE;
          if (sts_i.emit_ok) state_d = after_item;
        end else if (sts_i.top_lparen) begin
          cmd_o.pop = 1'b1;
          state_d   = after_item;
        end else begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = itp_pkg::SRC_TOP;
          cmd_o.pop  = sts_i.emit_ok;
        end
      end
      S_OPPOP: begin
        if (!sts_i.empty && sts_i.pop_cond) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = itp_pkg::SRC_TOP;
          cmd_o.pop  = sts_i.emit_ok;
        end else if (sts_i.full) begin
          cmd_o.emit        = 1'b1;
          cmd_o.mark_status = itp_pkg::ST_OVERFLOW;
          if (sts_i.emit_ok) state_d = after_item;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = after_item;
        end
      end
      S_FLUSH: begin
        if (!sts_i.empty) begin
          if (sts_i.top_lparen) begin
            cmd_o.pop      = 1'b1;
            cmd_o.set_open = 1'b1;
          end else begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = itp_pkg::SRC_TOP;
            cmd_o.pop  = sts_i.emit_ok;
          end
        end else if (sts_i.open_seen) begin
          cmd_o.emit        = 1'b1;
          cmd_o.mark_status = itp_pkg::ST_OPEN;
          if (sts_i.emit_ok) state_d = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/itp_dpath.sv @@
module itp_dpath #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        symbol_i,
  input  logic              end_of_expression_i,
  input  itp_pkg::itp_cmd_t cmd_i,
  output itp_pkg::itp_sts_t sts_o,
  output logic              out_tvalid_o,
  input  logic              out_tready_i,
  output logic [7:0]        out_symbol_o,
  output logic              out_valid_o,
  output logic              out_last_o,
  output logic [1:0]        status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [7:0]        sym_q;
  logic              last_q;
  logic              open_q;
  logic [CW-1:0]     count_q, count_d;
  logic [7:0]        top_q;
  logic [7:0]        rd_q;
  logic [7:0]        mem [STACK_DEPTH];

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic              hold_vld_q;
  logic [7:0]        hold_sym_q;
  logic              hold_chr_q;
  itp_pkg::status_e  hold_st_q;

  logic              m_vld_q;
  logic [7:0]        m_sym_q;
  logic              m_chr_q;
  logic              m_last_q;
  itp_pkg::status_e  m_st_q;

  logic [7:0]        new_sym;
  logic              new_chr;
  itp_pkg::status_e  new_st;
  logic              out_free, emit_ok, emit_fire;
  logic              load_new, load_hold, hold_load, fin;
  logic [1:0]        top_prec, sym_prec;

  // Result selection
  always_comb begin
    case (cmd_i.src)
      itp_pkg::SRC_SYMBOL: begin
        new_sym = sym_q;
        new_chr = 1'b1;
        new_st  = itp_pkg::ST_OK;
      end
      itp_pkg::SRC_TOP: begin
        new_sym = top_q;
        new_chr = 1'b1;
        new_st  = itp_pkg::ST_OK;
      end
      default: begin
        new_sym = 8'd0;
        new_chr = 1'b0;
        new_st  = cmd_i.mark_status;
      end
    endcase
  end

  // A final item keeps its newest result back until the end is known
  assign out_free  = !m_vld_q || out_tready_i;
  assign emit_ok   = last_q ? (!hold_vld_q || out_free) : out_free;
  assign emit_fire = cmd_i.emit && emit_ok;
  assign load_new  = emit_fire && !last_q;
  assign load_hold = emit_fire && last_q && hold_vld_q;
  assign hold_load = emit_fire && last_q;
  assign fin       = cmd_i.finish && out_free;

  // Stack: top in a register, the rest in memory; rd_q tracks the entry below
  assign count_d = count_q + CW'(cmd_i.push) - CW'(cmd_i.pop);
  assign wr_en   = cmd_i.push && (count_q != '0);
  assign wr_addr = AW'(count_q - CW'(1));
  assign rd_en   = count_d >= CW'(2);
  assign rd_addr = AW'(count_d - CW'(2));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    if (rd_en) begin
      rd_q <= (wr_en && (wr_addr == rd_addr)) ? top_q : mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q <= symbol_i;
    end
    if (cmd_i.push) begin
      top_q <= sym_q;
    end else if (cmd_i.pop) begin
      top_q <= rd_q;
    end
    if (hold_load) begin
      hold_sym_q <= new_sym;
      hold_chr_q <= new_chr;
      hold_st_q  <= new_st;
    end
    if (load_new) begin
      m_sym_q  <= new_sym;
      m_chr_q  <= new_chr;
      m_st_q   <= new_st;
      m_last_q <= 1'b0;
    end else if (load_hold) begin
      m_sym_q  <= hold_sym_q;
      m_chr_q  <= hold_chr_q;
      m_st_q   <= hold_st_q;
      m_last_q <= 1'b0;
    end else if (fin) begin
      m_sym_q  <= hold_vld_q ? hold_sym_q : 8'd0;
      m_chr_q  <= hold_vld_q && hold_chr_q;
      m_st_q   <= hold_vld_q ? hold_st_q : itp_pkg::ST_OK;
      m_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      last_q     <= 1'b0;
      open_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.capture) begin
        last_q <= end_of_expression_i;
        open_q <= 1'b0;
      end else if (cmd_i.set_open) begin
        open_q <= 1'b1;
      end
      if (hold_load) begin
        hold_vld_q <= 1'b1;
      end else if (fin) begin
        hold_vld_q <= 1'b0;
      end
      if (load_new || load_hold || fin) begin
        m_vld_q <= 1'b1;
      end else if (out_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  assign top_prec = itp_pkg::precedence(top_q);
  assign sym_prec = itp_pkg::precedence(sym_q);

  assign sts_o.cls        = itp_pkg::classify(sym_q);
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CW'(STACK_DEPTH));
  assign sts_o.top_lparen = (top_q == itp_pkg::CH_LPAREN);
  assign sts_o.pop_cond   = (top_prec > sym_prec) ||
                            ((top_prec == sym_prec) && (sym_q != itp_pkg::CH_CARET));
  assign sts_o.emit_ok    = emit_ok;
  assign sts_o.out_free   = out_free;
  assign sts_o.last       = last_q;
  assign sts_o.open_seen  = open_q;

  assign out_tvalid_o = m_vld_q;
  assign out_symbol_o = m_sym_q;
  assign out_valid_o  = m_chr_q;
  assign out_last_o   = m_last_q;
  assign status_o     = m_st_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> count_q < CW'(STACK_DEPTH))
    else $error("push onto a full stack");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> count_q != '0)
    else $error("pop from an empty stack");

  a_hold_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> last_q)
    else $error("held result outside a final item");

endmodule

@@ sv/infix_to_postfix_converter_unit.sv @@
// Shunting-yard infix to postfix converter. Each input transaction carries one
// ASCII character; letters and digits pass straight out, parentheses and the
// operators ^ (right-associative, highest), * / and + - go through an operator
// stack of STACK_DEPTH entries. tlast on the input marks the final character,
// after which the stack is flushed and the last output transaction carries
// tlast. Output tuser is 1 for a character and 0 for a marker; a marker carries
// a status code (unmatched close, stack overflow, unmatched open) or, when the
// final character released nothing, a bare end with status ok. One character
// is handled at a time; the input is not ready again until it is done. An
// operator first pops each stacked entry that takes precedence over it and is
// then pushed; a ')' releases each operator above its '(' and then pops the '(';
// the stack gives up one entry per cycle while results are taken. A final
// character then flushes the stack, ends the flush (giving the unmatched-open
// marker where one is due) and releases the closing transaction. A stalled
// output holds the sequencer only when a result has nowhere to go.
module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // end_of_expression
  // Output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_symbol, [9:8] status, rest zero
  output logic        m_axis_tuser_o,   // out_valid
  output logic        m_axis_tlast_o    // out_last
);

  itp_pkg::itp_cmd_t cmd;
  itp_pkg::itp_sts_t sts;
  logic [7:0]        out_symbol;
  logic [1:0]        status;

  // Sequencer: walks each character through decode, pops and flush
  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: input capture, operator stack, held result and output register
  itp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .symbol_i            (s_axis_tdata_i),
    .end_of_expression_i (s_axis_tlast_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_tvalid_o        (m_axis_tvalid_o),
    .out_tready_i        (m_axis_tready_i),
    .out_symbol_o        (out_symbol),
    .out_valid_o         (m_axis_tuser_o),
    .out_last_o          (m_axis_tlast_o),
    .status_o            (status)
  );

  // Pack the output transaction, padding to whole bytes
  assign m_axis_tdata_o = {6'd0, status, out_symbol};

endmodule

@@ tb/sv/infix_to_postfix_converter_checker.sv @@
module infix_to_postfix_converter_checker #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [7:0]  in_tdata_i,    // [7:0] symbol
  input  logic        in_tlast_i,    // end_of_expression
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  input  logic [15:0] out_tdata_i,   // [7:0] out_symbol, [9:8] status, rest zero
  input  logic        out_tuser_i,   // out_valid
  input  logic        out_tlast_i,   // out_last
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic [7:0]       sym;
    itp_pkg::status_e status;
    logic             is_char;
    logic             is_last;
  } postfix_item_t;

  logic [7:0]    op_stack [STACK_DEPTH];
  int unsigned   depth_q;
  postfix_item_t postfix_q [$];
  int unsigned   result_idx;

  function automatic logic [1:0] op_rank(input logic [7:0] ch);
    if (ch == itp_pkg::CH_CARET) return 2'd3;
    if (ch == itp_pkg::CH_STAR || ch == itp_pkg::CH_SLASH) return 2'd2;
    if (ch == itp_pkg::CH_PLUS || ch == itp_pkg::CH_MINUS) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic is_operand_char(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
           (ch >= "0" && ch <= "9");
  endfunction

  function automatic postfix_item_t make_item(input logic [7:0] sym,
                                              input itp_pkg::status_e st,
                                              input logic is_char);
    postfix_item_t item;
    item.sym     = sym;
    item.status  = st;
    item.is_char = is_char;
    item.is_last = 1'b0;
    return item;
  endfunction

  // Returns 0 when the stack is full and the symbol is dropped.
  function automatic logic stack_push(input logic [7:0] ch);
    if (depth_q >= STACK_DEPTH) return 1'b0;
    op_stack[depth_q] = ch;
    depth_q++;
    return 1'b1;
  endfunction

  task automatic convert_char(input logic [7:0] ch, input logic final_ch);
    postfix_item_t step_q [$];
    postfix_item_t item;
    logic [7:0]    top_ch;
    logic [1:0]    rank;
    logic          found;
    logic          open_seen;
    logic          popping;
    if (is_operand_char(ch)) begin
      step_q.push_back(make_item(ch, itp_pkg::ST_OK, 1'b1));
    end else if (ch == itp_pkg::CH_LPAREN) begin
      if (!stack_push(ch)) step_q.push_back(make_item(8'h00, itp_pkg::ST_OVERFLOW, 1'b0));
    end else if (ch == itp_pkg::CH_RPAREN) begin
      found = 1'b0;
      while (depth_q > 0 && !found) begin
        depth_q--;
        top_ch = op_stack[depth_q];
        if (top_ch == itp_pkg::CH_LPAREN) found = 1'b1;
        else step_q.push_back(make_item(top_ch, itp_pkg::ST_OK, 1'b1));
      end
      if (!found) step_q.push_back(make_item(8'h00, itp_pkg::ST_CLOSE, 1'b0));
    end else if (op_rank(ch) != 2'd0) begin
      rank    = op_rank(ch);
      popping = 1'b1;
      while (depth_q > 0 && popping) begin
        top_ch = op_stack[depth_q - 1];
        if (op_rank(top_ch) > rank ||
            (op_rank(top_ch) == rank && ch != itp_pkg::CH_CARET)) begin
          depth_q--;
          step_q.push_back(make_item(top_ch, itp_pkg::ST_OK, 1'b1));
        end else begin
          popping = 1'b0;
        end
      end
      if (!stack_push(ch)) step_q.push_back(make_item(8'h00, itp_pkg::ST_OVERFLOW, 1'b0));
    end

    if (final_ch) begin
      open_seen = 1'b0;
      while (depth_q > 0) begin
        depth_q--;
        top_ch = op_stack[depth_q];
        if (top_ch == itp_pkg::CH_LPAREN) open_seen = 1'b1;
        else step_q.push_back(make_item(top_ch, itp_pkg::ST_OK, 1'b1));
      end
      if (open_seen) step_q.push_back(make_item(8'h00, itp_pkg::ST_OPEN, 1'b0));
      else if (step_q.size() == 0) step_q.push_back(make_item(8'h00, itp_pkg::ST_OK, 1'b0));
    end

    foreach (step_q[i]) begin
      item         = step_q[i];
      item.is_last = final_ch && (i == step_q.size() - 1);
      postfix_q.push_back(item);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] result %0d: %s is %0h, expected %0h", $time, result_idx, field, got,
             want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    postfix_item_t want;
    if (!rst_ni) begin
      depth_q = 0;
      postfix_q.delete();
      outstanding_o = 0;
      mismatches_o  = 0;
      result_idx    = 0;
    end else begin
      // Compare first: a result leaving now belongs to an earlier character.
      if (out_tvalid_i && out_tready_i) begin
        if (postfix_q.size() == 0) begin
          report_mismatch("unexpected result, tdata", out_tdata_i, 16'h0000);
        end else begin
          want = postfix_q.pop_front();
          if (out_tdata_i[7:0] !== want.sym)
            report_mismatch("out_symbol", {8'h00, out_tdata_i[7:0]}, {8'h00, want.sym});
          if (out_tdata_i[9:8] !== want.status)
            report_mismatch("status", {14'h0, out_tdata_i[9:8]}, {14'h0, want.status});
          if (out_tdata_i[15:10] !== 6'h00)
            report_mismatch("tdata padding", {10'h0, out_tdata_i[15:10]}, 16'h0000);
          if (out_tuser_i !== want.is_char)
            report_mismatch("out_valid", {15'h0, out_tuser_i}, {15'h0, want.is_char});
          if (out_tlast_i !== want.is_last)
            report_mismatch("out_last", {15'h0, out_tlast_i}, {15'h0, want.is_last});
        end
        result_idx++;
      end
      if (in_tvalid_i && in_tready_i) convert_char(in_tdata_i, in_tlast_i);
      outstanding_o = postfix_q.size();
    end
  end

endmodule

@@ tb/sv/infix_to_postfix_converter_unit_test.sv @@
module infix_to_postfix_converter_unit_test;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned RANDOM_ITEMS = 230;
  // Worst case is far below this: even every character releasing a full stack
  // with the longest stall on every transaction stays well inside it.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * STACK_DEPTH;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;   // [7:0] symbol
  logic        s_tlast  = 1'b0;    // end_of_expression
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // [7:0] out_symbol, [9:8] status, rest zero
  logic        m_tuser;            // out_valid
  logic        m_tlast;            // out_last

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycles     = 0;
  int unsigned live_items = 0;
  // While set, neither side idles: gives back-to-back stretches.
  logic        calm       = 1'b0;
  logic [7:0]  run_q [$];

  always #6 clk = ~clk;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  infix_to_postfix_converter_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_tvalid_i   (s_tvalid),
    .in_tready_i   (s_tready),
    .in_tdata_i    (s_tdata),
    .in_tlast_i    (s_tlast),
    .out_tvalid_i  (m_tvalid),
    .out_tready_i  (m_tready),
    .out_tdata_i   (m_tdata),
    .out_tuser_i   (m_tuser),
    .out_tlast_i   (m_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("a") + 8'($urandom_range(0, 25));
      1:       return 8'("A") + 8'($urandom_range(0, 25));
      default: return 8'("0") + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_CARET;
      1:       return itp_pkg::CH_STAR;
      2:       return itp_pkg::CH_SLASH;
      3:       return itp_pkg::CH_PLUS;
      default: return itp_pkg::CH_MINUS;
    endcase
  endfunction

  // Drive one character at the falling edge after a random gap and hold it
  // until the transaction completes at a rising edge.
  task automatic send_char(input logic [7:0] sym, input logic fin);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    if (itp_pkg::classify(sym) != itp_pkg::CLS_OTHER) live_items++;
  endtask

  task automatic send_text(input string text, input logic fin);
    for (int i = 0; i < text.len(); i++)
      send_char(8'(text[i]), fin && (i == text.len() - 1));
  endtask

  // Send the built run, marking its final character as the end of expression.
  task automatic send_run();
    foreach (run_q[i]) send_char(run_q[i], i == run_q.size() - 1);
  endtask

  // Well-formed expression with random operands, operators and nesting.
  task automatic build_expression();
    int unsigned terms;
    int unsigned open_cnt;
    run_q.delete();
    open_cnt = 0;
    terms    = $urandom_range(1, 8);
    for (int i = 0; i < terms; i++) begin
      while ($urandom_range(0, 3) == 0 && open_cnt < 6) begin
        run_q.push_back(itp_pkg::CH_LPAREN);
        open_cnt++;
      end
      run_q.push_back(pick_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        run_q.push_back(itp_pkg::CH_RPAREN);
        open_cnt--;
      end
      if (i != terms - 1) run_q.push_back(pick_operator());
    end
    while (open_cnt > 0) begin
      run_q.push_back(itp_pkg::CH_RPAREN);
      open_cnt--;
    end
  endtask

  // Nest around the stack depth so that both '(' and operators hit a full
  // stack; leave some opens unmatched for the flush.
  task automatic build_deep_nest();
    int unsigned opens;
    int unsigned ops;
    int unsigned closes;
    run_q.delete();
    opens = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 3);
    repeat (opens) run_q.push_back(itp_pkg::CH_LPAREN);
    run_q.push_back(pick_operand());
    ops = $urandom_range(0, 4);
    repeat (ops) begin
      run_q.push_back($urandom_range(0, 1) ? itp_pkg::CH_CARET : pick_operator());
      run_q.push_back(pick_operand());
    end
    closes = $urandom_range(0, 8);
    repeat (closes) run_q.push_back(itp_pkg::CH_RPAREN);
  endtask

  // Arbitrary mix of valid tokens: broken expressions and stray parentheses.
  task automatic build_scramble();
    int unsigned len;
    run_q.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       run_q.push_back(pick_operand());
        1:       run_q.push_back(pick_operator());
        2:       run_q.push_back(itp_pkg::CH_LPAREN);
        default: run_q.push_back(itp_pkg::CH_RPAREN);
      endcase
    end
  endtask

  // Output side: draw a stall for every result, then hold ready until the
  // transaction completes.
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned drain;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: all operators, right-associative '^' against
    // left-associative pops, operand range extremes, a bracketed group.
    send_text("A+b*Z^a^z/(0-9)", 1'b1);
    // Unmatched close on an empty stack, then one that pops an operator first.
    send_text(")", 1'b0);
    send_text("c-d)", 1'b0);
    // Unmatched open found by the flush.
    send_text("(z", 1'b1);
    // Ignored characters, the last one ending an expression that gives nothing.
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        build_expression();
        send_run();
      end else if (pick < 74) begin
        build_deep_nest();
        send_run();
      end else if (pick < 88) begin
        build_scramble();
        send_run();
      end else begin
        // Raw bytes over the whole range, ending the expression half the time.
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_char(8'($urandom_range(0, 255)), (i == len - 1) && $urandom_range(0, 1));
      end
    end
    // Close off any expression left open by noise so the stack ends empty.
    send_char(pick_operand(), 1'b1);
    calm = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    drain = DRAIN_CYCLES;
    repeat (drain) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
